[rtl/spd_pkg.sv]
// Package for the spin pattern detector.
// Holds register indexes, reset values, limits and the result item layout.
// No dependencies.
`default_nettype none

package spd_pkg;

   localparam int unsigned POS_W    = 16;
   localparam int unsigned TIME_W   = 64;
   localparam int unsigned PERIOD_W = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned DIR_CNT_W  = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COORDINATE_KIND     = 3'd0,
      CSR_MIN_JUMP            = 3'd1,
      CSR_QUICK_PERIOD_MIN_NS = 3'd2,
      CSR_QUICK_PERIOD_MAX_NS = 3'd3,
      CSR_SLOW_PERIOD_MAX_NS  = 3'd4
   } csr_index_type;

   typedef enum logic {
      KIND_SPHERE = 1'b0,
      KIND_PLANE  = 1'b1
   } coord_kind_type;

   typedef enum logic {
      MODE_OBSERVE = 1'b0,
      MODE_RESTART = 1'b1
   } req_mode_type;

   localparam logic [POS_W-1:0]    MIN_JUMP_RST    = 16'd4096;
   localparam logic [PERIOD_W-1:0] QUICK_MIN_RST   = 32'd20000000;
   localparam logic [PERIOD_W-1:0] QUICK_MAX_RST   = 32'd300000000;
   localparam logic [PERIOD_W-1:0] SLOW_MAX_RST    = 32'd1000000000;
   localparam logic [DIR_CNT_W-1:0] SPHERE_DIR_LIMIT = 6'd25;
   localparam logic [DIR_CNT_W-1:0] PLANE_DIR_LIMIT  = 6'd40;
   localparam logic [1:0] JUMPS_MAX = 2'd2;

   typedef struct packed {
      logic [3:0]          pad;
      logic [PERIOD_W-1:0] period_ns;
      logic                turn_positive;
      logic                slow_spin;
      logic                quick_spin;
      logic                spinning;
   } rsp_data_type;

endpackage

`default_nettype wire

[rtl/spin_pattern_detector_core.sv]
// Each item passes through the input register, then the result register. Throughput: one
// item per cycle while rsp_tready does not stall the result; the state loop is elapsed-time
// subtraction and window compares on the registered item.
// Synchronous active-high reset clears the tracking state, both valid stages and
// loads the configuration registers with their defaults.
// Top level of the spin pattern detector; uses spd_pkg.
`default_nettype none

module spin_pattern_detector_core
   import spd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Bits from low up: position[15:0], timestamp_ns[79:16].
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Bits from low up: mode[0].
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Bits from low up: spinning, quick_spin, slow_spin, turn_positive,
   // period_ns[35:4], zero padding[39:36].
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   coord_kind_type      kind_ff;
   logic [POS_W-1:0]    min_jump_ff;
   logic [PERIOD_W-1:0] quick_min_ff, quick_max_ff, slow_max_ff;

   logic                in_valid_ff;
   req_mode_type        in_mode_ff;
   logic [POS_W-1:0]    in_pos_ff;
   logic [TIME_W-1:0]   in_time_ff;

   logic                 out_valid_ff;
   rsp_data_type         out_data_ff, out_data_in;

   logic [POS_W-1:0]     last_pos_ff, last_pos_in;
   logic                 last_neg_ff, last_neg_in;
   logic [TIME_W-1:0]    last_jump_time_ff, last_jump_time_in;
   logic [1:0]           jumps_ff, jumps_in;
   logic [DIR_CNT_W-1:0] dir_cnt_ff, dir_cnt_in;
   logic                 quick_ff, quick_in;
   logic                 slow_ff, slow_in;
   logic                 dir_ff, dir_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;

   logic                 advance;
   logic [TIME_W-1:0]    elapsed;
   logic                 over_slow, over_quick, over_min;
   logic [POS_W-1:0]     wrap_delta;
   logic [POS_W:0]       delta, mag;
   logic                 neg, is_jump;
   logic [DIR_CNT_W-1:0] dir_limit;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_SPHERE;
         min_jump_ff  <= MIN_JUMP_RST;
         quick_min_ff <= QUICK_MIN_RST;
         quick_max_ff <= QUICK_MAX_RST;
         slow_max_ff  <= SLOW_MAX_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_COORDINATE_KIND:     kind_ff      <= coord_kind_type'(csr_wdata[0]);
            CSR_MIN_JUMP:            min_jump_ff  <= csr_wdata[POS_W-1:0];
            CSR_QUICK_PERIOD_MIN_NS: quick_min_ff <= csr_wdata;
            CSR_QUICK_PERIOD_MAX_NS: quick_max_ff <= csr_wdata;
            CSR_SLOW_PERIOD_MAX_NS:  slow_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_mode_ff <= req_mode_type'(req_tuser);
         in_pos_ff  <= req_tdata[POS_W-1:0];
         in_time_ff <= req_tdata[POS_W +: TIME_W];
      end
   end

   assign elapsed    = in_time_ff - last_jump_time_ff;
   assign over_slow  = elapsed > {32'd0, slow_max_ff};
   assign over_quick = elapsed > {32'd0, quick_max_ff};
   assign over_min   = elapsed > {32'd0, quick_min_ff};
   assign wrap_delta = in_pos_ff - last_pos_ff;
   assign delta      = (kind_ff == KIND_SPHERE)
                     ? {wrap_delta[POS_W-1], wrap_delta}
                     : {in_pos_ff[POS_W-1], in_pos_ff} - {last_pos_ff[POS_W-1], last_pos_ff};
   assign neg        = delta[POS_W];
   assign mag        = neg ? (~delta + 17'd1) : delta;
   assign is_jump    = mag > {1'b0, min_jump_ff};
   assign dir_limit  = (kind_ff == KIND_SPHERE) ? SPHERE_DIR_LIMIT : PLANE_DIR_LIMIT;

   always_comb begin
      last_pos_in       = last_pos_ff;
      last_neg_in       = last_neg_ff;
      last_jump_time_in = last_jump_time_ff;
      jumps_in          = jumps_ff;
      dir_cnt_in        = dir_cnt_ff;
      quick_in          = quick_ff;
      slow_in           = slow_ff;
      dir_in            = dir_ff;
      period_in         = period_ff;
      if (in_mode_ff == MODE_RESTART) begin
         jumps_in    = 2'd0;
         last_pos_in = '0;
         dir_cnt_in  = '0;
      end else begin
         if ((slow_ff || quick_ff) && over_slow) begin
            slow_in  = 1'b0;
            quick_in = 1'b0;
            jumps_in = 2'd0;
         end else if (over_quick && quick_ff) begin
            slow_in  = 1'b1;
            quick_in = 1'b0;
         end
         if (is_jump) begin
            dir_cnt_in = '0;
            if (jumps_in != JUMPS_MAX) begin
               jumps_in = jumps_in + 2'd1;
            end
            if (jumps_in == JUMPS_MAX && last_neg_ff == neg) begin
               if (over_quick && (elapsed < {32'd0, slow_max_ff})) begin
                  slow_in  = 1'b1;
                  quick_in = 1'b0;
               end else if (over_min) begin
                  quick_in = 1'b1;
                  slow_in  = 1'b0;
               end
               if (over_min) begin
                  period_in = (elapsed[TIME_W-1:PERIOD_W] != '0) ? '1
                                                                 : elapsed[PERIOD_W-1:0];
                  dir_in    = !neg;
               end
            end
            last_jump_time_in = in_time_ff;
            last_neg_in       = neg;
         end else if (neg == last_neg_ff) begin
            dir_cnt_in = dir_cnt_ff + 6'd1;
            if (dir_cnt_in > dir_limit) begin
               dir_cnt_in = '0;
               jumps_in   = 2'd0;
               quick_in   = 1'b0;
               slow_in    = 1'b0;
            end
         end else begin
            dir_cnt_in = '0;
         end
         last_pos_in = in_pos_ff;
      end
   end

   always_comb begin
      out_data_in.pad           = '0;
      out_data_in.period_ns     = period_in;
      out_data_in.turn_positive = dir_in;
      out_data_in.slow_spin     = slow_in;
      out_data_in.quick_spin    = quick_in;
      out_data_in.spinning      = quick_in || slow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff       <= '0;
         last_neg_ff       <= 1'b0;
         last_jump_time_ff <= '0;
         jumps_ff          <= 2'd0;
         dir_cnt_ff        <= '0;
         quick_ff          <= 1'b0;
         slow_ff           <= 1'b0;
         dir_ff            <= 1'b0;
         period_ff         <= '0;
         out_valid_ff      <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            last_pos_ff       <= last_pos_in;
            last_neg_ff       <= last_neg_in;
            last_jump_time_ff <= last_jump_time_in;
            jumps_ff          <= jumps_in;
            dir_cnt_ff        <= dir_cnt_in;
            quick_ff          <= quick_in;
            slow_ff           <= slow_in;
            dir_ff            <= dir_in;
            period_ff         <= period_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

[rtl/spd_checker.sv]
// Port-level checker for the spin pattern detector and its bind to the top level.
// Uses spd_pkg for the result item layout.
`default_nettype none

module spd_checker
   import spd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   rsp_data_type rsp;
   assign rsp = rsp_tdata;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_spin_or: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.spinning == (rsp.quick_spin || rsp.slow_spin))
      else $error("spinning is not quick or slow");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.quick_spin && rsp.slow_spin))
      else $error("quick and slow spin both set");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind spin_pattern_detector_core spd_checker u_spd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[verif/tb.sv]
// Testbench for spin_pattern_detector_core: directed spin sequences, register extremes,
// random spin traffic under idle and stall mixes, and a long result hold-off.
// Depends on spd_pkg and the core; results are checked against an in-bench tracker.
module tb;
   import spd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] MS = 64'd1_000_000;
   localparam logic [63:0] TS_MAX = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned LONG_HOLD = 300;
   localparam int unsigned DRAIN_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // Bits from low up: position[15:0], timestamp_ns[79:16].
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // Bits from low up: mode[0].
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // Bits from low up: spinning, quick_spin, slow_spin, turn_positive, period_ns, padding.
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   spin_pattern_detector_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5ns clock = ~clock;

   coord_kind_type cfg_kind = KIND_SPHERE;
   logic [15:0] cfg_min_jump = MIN_JUMP_RST;
   logic [31:0] cfg_quick_min = QUICK_MIN_RST;
   logic [31:0] cfg_quick_max = QUICK_MAX_RST;
   logic [31:0] cfg_slow_max = SLOW_MAX_RST;

   logic [15:0] trk_last_pos = '0;
   logic trk_last_neg = 1'b0;
   logic [63:0] trk_jump_time = '0;
   int unsigned trk_jumps = 0;
   int unsigned trk_same_dir = 0;
   logic trk_quick = 1'b0;
   logic trk_slow = 1'b0;
   logic trk_dir = 1'b0;
   logic [31:0] trk_period = '0;

   rsp_data_type expected_status_q[$];

   logic [15:0] stim_pos = '0;
   logic [63:0] stim_time = 64'd4_000_000_000;
   logic stim_neg = 1'b0;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_off_requests = 0;
   int unsigned hold_off_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;

   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned restarts_sent = 0;
   int unsigned results_checked = 0;
   int unsigned quick_seen = 0;
   int unsigned slow_seen = 0;
   int unsigned settings_used = 1;

   function automatic rsp_data_type predict_spin_status(req_mode_type mode, logic [15:0] pos,
                                                       logic [63:0] stamp);
      logic [63:0] elapsed;
      logic [15:0] wrapped;
      logic [16:0] delta;
      logic [16:0] mag;
      logic neg;
      logic [DIR_CNT_W-1:0] limit;
      rsp_data_type status;
      if (mode == MODE_RESTART) begin
         trk_jumps = 0;
         trk_last_pos = '0;
         trk_same_dir = 0;
      end else begin
         elapsed = stamp - trk_jump_time;
         if ((trk_quick || trk_slow) && elapsed > {32'd0, cfg_slow_max}) begin
            trk_quick = 1'b0;
            trk_slow = 1'b0;
            trk_jumps = 0;
         end else if (trk_quick && elapsed > {32'd0, cfg_quick_max}) begin
            trk_quick = 1'b0;
            trk_slow = 1'b1;
         end
         if (cfg_kind == KIND_SPHERE) begin
            wrapped = pos - trk_last_pos;
            delta = {wrapped[15], wrapped};
         end else begin
            delta = {pos[15], pos} - {trk_last_pos[15], trk_last_pos};
         end
         neg = delta[16];
         mag = neg ? -delta : delta;
         if (mag > {1'b0, cfg_min_jump}) begin
            trk_same_dir = 0;
            if (trk_jumps < 2) trk_jumps++;
            if (trk_jumps == 2 && trk_last_neg == neg) begin
               if (elapsed > {32'd0, cfg_quick_max} && elapsed < {32'd0, cfg_slow_max}) begin
                  trk_slow = 1'b1;
                  trk_quick = 1'b0;
               end else if (elapsed > {32'd0, cfg_quick_min}) begin
                  trk_quick = 1'b1;
                  trk_slow = 1'b0;
               end
               if (elapsed > {32'd0, cfg_quick_min}) begin
                  trk_period = (elapsed > 64'hFFFF_FFFF) ? '1 : elapsed[31:0];
                  trk_dir = !neg;
               end
            end
            trk_jump_time = stamp;
            trk_last_neg = neg;
         end else if (neg == trk_last_neg) begin
            limit = (cfg_kind == KIND_SPHERE) ? SPHERE_DIR_LIMIT : PLANE_DIR_LIMIT;
            trk_same_dir++;
            if (trk_same_dir > limit) begin
               trk_same_dir = 0;
               trk_jumps = 0;
               trk_quick = 1'b0;
               trk_slow = 1'b0;
            end
         end else begin
            trk_same_dir = 0;
         end
         trk_last_pos = pos;
      end
      status.pad = '0;
      status.period_ns = trk_period;
      status.turn_positive = trk_dir;
      status.slow_spin = trk_slow;
      status.quick_spin = trk_quick;
      status.spinning = trk_quick | trk_slow;
      return status;
   endfunction

   function automatic logic [63:0] spacing_sample();
      case ($urandom_range(9))
         0: return 64'($urandom_range(cfg_quick_min, 0));
         1: return 64'(cfg_quick_min);
         2: return 64'(cfg_quick_min) + 64'd1;
         3, 4, 5: return 64'($urandom_range(cfg_quick_max, cfg_quick_min));
         6: return 64'(cfg_quick_max);
         7: return 64'($urandom_range(cfg_slow_max, cfg_quick_max));
         8: return 64'(cfg_slow_max);
         default: return 64'(cfg_slow_max) + 64'($urandom_range(500_000_000, 1));
      endcase
   endfunction

   task automatic send_item(req_mode_type mode, logic [15:0] pos, logic [63:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {stamp, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_status_q.push_back(predict_spin_status(mode, pos, stamp));
      items_sent++;
      if (mode == MODE_RESTART) restarts_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_COORDINATE_KIND: cfg_kind = coord_kind_type'(value[0]);
         CSR_MIN_JUMP: cfg_min_jump = value[15:0];
         CSR_QUICK_PERIOD_MIN_NS: cfg_quick_min = value;
         CSR_QUICK_PERIOD_MAX_NS: cfg_quick_max = value;
         CSR_SLOW_PERIOD_MAX_NS: cfg_slow_max = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Upper bits beyond each register's width are random and must be ignored.
   task automatic apply_config(coord_kind_type kind, logic [15:0] jump, logic [31:0] qmin,
                               logic [31:0] qmax, logic [31:0] smax);
      logic [31:0] noise;
      noise = $urandom;
      put_csr(CSR_COORDINATE_KIND, {noise[31:1], kind});
      put_csr(CSR_MIN_JUMP, {noise[15:0], jump});
      put_csr(CSR_QUICK_PERIOD_MIN_NS, qmin);
      put_csr(CSR_QUICK_PERIOD_MAX_NS, qmax);
      put_csr(CSR_SLOW_PERIOD_MAX_NS, smax);
      csr_wen <= 1'b0;
      settings_used++;
   endtask

   task automatic send_spin_traffic(int unsigned count);
      int unsigned sent;
      int unsigned choice;
      int unsigned len;
      int unsigned small_max;
      logic [15:0] step;
      logic rev;
      sent = 0;
      while (sent < count) begin
         choice = $urandom_range(99);
         small_max = (cfg_min_jump < 16'd2000) ? cfg_min_jump : 2000;
         if (choice < 50) begin
            if ($urandom_range(15) == 0) stim_neg = !stim_neg;
            step = cfg_min_jump + 16'($urandom_range(3000, 1));
            stim_time += spacing_sample();
            stim_pos = stim_neg ? stim_pos - step : stim_pos + step;
            send_item(MODE_OBSERVE, stim_pos, stim_time);
            sent++;
         end else if (choice < 80) begin
            len = (choice < 74) ? $urandom_range(30, 1) : $urandom_range(48, 42);
            repeat (len) begin
               step = 16'($urandom_range(small_max, (choice < 74) ? 0 : 1));
               rev = (choice < 74) && ($urandom_range(19) == 0);
               stim_time += 64'($urandom_range(20_000_000, 2_000_000));
               stim_pos = (stim_neg ^ rev) ? stim_pos - step : stim_pos + step;
               send_item(MODE_OBSERVE, stim_pos, stim_time);
               sent++;
            end
         end else if (choice < 86) begin
            send_item(MODE_RESTART, 16'($urandom), {$urandom, $urandom});
            sent++;
         end else if (choice < 93) begin
            stim_pos = 16'($urandom);
            stim_time += 64'($urandom_range(20_000_000, 2_000_000));
            send_item(MODE_OBSERVE, stim_pos, stim_time);
            sent++;
         end else begin
            if ($urandom_range(1) == 0) stim_time -= 64'($urandom);
            else stim_time = {$urandom, $urandom};
            stim_pos = stim_pos + 16'($urandom_range(small_max, 0));
            send_item(MODE_OBSERVE, stim_pos, stim_time);
            sent++;
         end
      end
   endtask

   task automatic test_directed_sphere();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(MODE_OBSERVE, 16'd0, 64'd0);
      send_item(MODE_OBSERVE, 16'd8000, 100 * MS);
      send_item(MODE_OBSERVE, 16'd16000, 200 * MS);
      send_item(MODE_OBSERVE, 16'd24000, 210 * MS);
      send_item(MODE_OBSERVE, 16'd32000, 710 * MS);
      send_item(MODE_OBSERVE, 16'd31990, 1800 * MS);
      send_item(MODE_RESTART, 16'h7FFF, TS_MAX);
      send_item(MODE_OBSERVE, 16'h8000, 1900 * MS);
      send_item(MODE_OBSERVE, 16'h0000, 2000 * MS);
      send_item(MODE_OBSERVE, 16'h4000, 1 * MS);
      send_item(MODE_OBSERVE, 16'h7FFF, TS_MAX);
      send_item(MODE_OBSERVE, 16'h8000, 64'd0);
      wait_drained();
   endtask

   task automatic test_directed_plane();
      apply_config(KIND_PLANE, MIN_JUMP_RST, QUICK_MIN_RST, QUICK_MAX_RST, SLOW_MAX_RST);
      send_item(MODE_RESTART, 16'h0000, 64'd0);
      send_item(MODE_OBSERVE, 16'h7FFF, 3100 * MS);
      send_item(MODE_OBSERVE, 16'h8000, 3200 * MS);
      send_item(MODE_OBSERVE, 16'h0000, 3300 * MS);
      send_item(MODE_OBSERVE, 16'h7FFF, 3400 * MS);
      send_item(MODE_OBSERVE, 16'h7FFF, 3400 * MS);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      put_csr(CSR_UNUSED_INDEX, $urandom);
      apply_config(KIND_SPHERE, 16'h0000, 32'd0, 32'd0, 32'd0);
      send_spin_traffic(40);
      wait_drained();
      apply_config(KIND_PLANE, 16'hFFFF, '1, '1, '1);
      send_spin_traffic(40);
      wait_drained();
      apply_config(KIND_SPHERE, 16'h0001, 32'd1, '1, '1);
      send_spin_traffic(40);
      wait_drained();
      apply_config(KIND_PLANE, 16'd2000, QUICK_MAX_RST, QUICK_MIN_RST, QUICK_MIN_RST);
      send_spin_traffic(40);
      wait_drained();
   endtask

   task automatic test_random_phases();
      int unsigned idle_mix [4] = '{0, 75, 0, 27};
      int unsigned stall_mix [4] = '{0, 0, 75, 27};
      logic [31:0] qmin;
      logic [31:0] qmax;
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_mix[phase];
         rsp_stall_pct = stall_mix[phase];
         qmin = $urandom_range(40_000_000, 1_000_000);
         qmax = qmin + $urandom_range(400_000_000, 1);
         apply_config(coord_kind_type'(phase[0]), 16'($urandom_range(12000, 64)), qmin, qmax,
                      qmax + $urandom_range(1_500_000_000, 1));
         send_spin_traffic(210);
         wait_drained();
      end
   endtask

   task automatic test_result_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      apply_config(KIND_SPHERE, MIN_JUMP_RST, QUICK_MIN_RST, QUICK_MAX_RST, SLOW_MAX_RST);
      hold_off_requests++;
      send_spin_traffic(80);
      wait_drained();
   endtask

   always @(negedge clock) begin
      if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_data_type got;
      rsp_data_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_status_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("ERROR: unexpected result item %h", got);
         end else begin
            want = expected_status_q.pop_front();
            results_checked++;
            if (got.spinning !== want.spinning || got.quick_spin !== want.quick_spin ||
                got.slow_spin !== want.slow_spin || got.turn_positive !== want.turn_positive ||
                got.period_ns !== want.period_ns || got.pad !== want.pad) begin
               error_count++;
               if (error_count <= 10)
                  $display({"ERROR: result %0d expected spin %b quick %b slow %b turn %b ",
                            "period %0d pad %h, got spin %b quick %b slow %b turn %b ",
                            "period %0d pad %h"}, results_checked,
                           want.spinning, want.quick_spin, want.slow_spin,
                           want.turn_positive, want.period_ns, want.pad,
                           got.spinning, got.quick_spin, got.slow_spin,
                           got.turn_positive, got.period_ns, got.pad);
            end
            if (got.quick_spin) quick_seen++;
            if (got.slow_spin) slow_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_status_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed_sphere();
      test_directed_plane();
      test_register_extremes();
      test_random_phases();
      test_result_backpressure();
      wait_drained();
      $display("Sent %0d items (%0d soft restarts) under %0d register settings in both modes,",
               items_sent, restarts_sent, settings_used);
      $display("with idle/stall mixes and a long hold-off; %0d results (%0d quick, %0d slow).",
               results_checked, quick_seen, slow_seen);
      if (error_count == 0 && expected_status_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Errors: %0d", error_count);
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/spd_pkg.sv
rtl/spin_pattern_detector_core.sv
rtl/spd_checker.sv
verif/tb.sv
